@@ hdl/hog_cell_histogram_defines.svh @@
// ----------------------------------------------------------------------------
// HOG cell histogram assertion macros
// Shared assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef HOG_CELL_HISTOGRAM_DEFINES_SVH
`define HOG_CELL_HISTOGRAM_DEFINES_SVH

`ifndef SYNTHESIS
`define HOGCH_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("hog_cell_histogram check failed");
`define HOGCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hog_cell_histogram check failed");
`else
`define HOGCH_ASSERT(lbl, expr)
`define HOGCH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/hogch_pkg.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram package
// Widths, limits, control structs and the octant decision shared by the block.
// ----------------------------------------------------------------------------
package hogch_pkg;

    localparam int ANGLE_BINS  = 8;
    localparam int BIN_W       = $clog2(ANGLE_BINS);
    localparam int PIX_W       = 8;
    localparam int GRAD_W      = PIX_W + 2;          // signed gradient with headroom
    localparam int SQ_W        = 2 * PIX_W + 1;      // gx^2 + gy^2
    localparam int RAD_W       = SQ_W + 9;           // radicand: sq * 256, even width
    localparam int MAG_W       = RAD_W / 2;          // root bits
    localparam int REM_W       = MAG_W + 2;
    localparam int ROOT_STEPS  = MAG_W;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int SUM_W       = 21;
    localparam logic [SUM_W-1:0] BIN_SUM_MAX = SUM_W'(1476864);

    typedef logic [BIN_W-1:0] t_bin;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic load;       // capture a new pixel
        logic square;     // form the radicand, clear the root unit
        logic root_step;  // one bit of the square root
        logic accum;      // add the magnitude into its bin
        logic snap;       // move all bins to the emission line and clear them
        logic shift;      // an output beat was taken
    } t_dp_cmd;

    typedef struct packed {
        logic cell_end;
    } t_dp_sts;

    // Sector of atan2(gy, gx) in 45 degree steps, y pointing down.
    // Angles exactly on a sector border belong to the higher sector.
    function automatic t_bin octant(input logic signed [GRAD_W-1:0] gx,
                                    input logic signed [GRAD_W-1:0] gy);
        t_bin b;
        if (gy >= 0) begin
            if (gx > 0) begin
                b = (gy < gx) ? t_bin'(0) : t_bin'(1);
            end else if (gx == 0) begin
                b = (gy == 0) ? t_bin'(0) : t_bin'(2);
            end else if (gy == 0) begin
                b = t_bin'(4);
            end else begin
                b = (gy > -gx) ? t_bin'(2) : t_bin'(3);
            end
        end else begin
            if (gx < 0) begin
                b = (gy > gx) ? t_bin'(4) : t_bin'(5);
            end else if (gx == 0) begin
                b = t_bin'(6);
            end else begin
                b = (-gy > gx) ? t_bin'(6) : t_bin'(7);
            end
        end
        return b;
    endfunction

endpackage

@@ hdl/hogch_datapath.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram datapath
// Gradient, squared magnitude, bit-serial square root, bin accumulators and
// the emission shift line.
// ----------------------------------------------------------------------------
module hogch_datapath import hogch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [PIX_W-1:0] i_pixel_left,
    input  logic [PIX_W-1:0] i_pixel_right,
    input  logic [PIX_W-1:0] i_pixel_above,
    input  logic [PIX_W-1:0] i_pixel_below,
    input  logic             i_cell_end,
    output t_sum             o_bin_sum
);

    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [PIX_W-1:0]         gx_abs;
    logic [PIX_W-1:0]         gy_abs;

    logic [PIX_W-1:0]   r_gx_abs;
    logic [PIX_W-1:0]   r_gy_abs;
    t_bin               r_bin;
    logic               r_cell_end;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    t_mag               r_root;
    t_sum               r_acc   [ANGLE_BINS];
    t_sum               r_shift [ANGLE_BINS];

    logic [2*PIX_W-1:0] gx_sq;
    logic [2*PIX_W-1:0] gy_sq;
    logic [SQ_W-1:0]    sq;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [SUM_W:0]     sum_wide;
    t_sum               sum_sat;

    assign gx = GRAD_W'(i_pixel_right) - GRAD_W'(i_pixel_left);
    assign gy = GRAD_W'(i_pixel_below) - GRAD_W'(i_pixel_above);
    assign gx_abs = gx[GRAD_W-1] ? PIX_W'(-gx) : PIX_W'(gx);
    assign gy_abs = gy[GRAD_W-1] ? PIX_W'(-gy) : PIX_W'(gy);

    assign gx_sq = r_gx_abs * r_gx_abs;
    assign gy_sq = r_gy_abs * r_gy_abs;
    assign sq    = SQ_W'(gx_sq) + SQ_W'(gy_sq);

    // Restoring square root: two radicand bits enter per step.
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    assign sum_wide = {1'b0, r_acc[r_bin]} + (SUM_W+1)'(r_root);
    assign sum_sat  = (sum_wide > {1'b0, BIN_SUM_MAX}) ? BIN_SUM_MAX : sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx_abs   <= gx_abs;
            r_gy_abs   <= gy_abs;
            r_bin      <= octant(gx, gy);
            r_cell_end <= i_cell_end;
        end
        if (i_cmd.square) begin
            r_rad  <= {1'b0, sq, 8'b0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ANGLE_BINS; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_cmd.accum) begin
            if (i_cmd.snap) begin
                for (int k = 0; k < ANGLE_BINS; k++) begin
                    r_acc[k] <= '0;
                end
            end else begin
                r_acc[r_bin] <= sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && i_cmd.snap) begin
            for (int k = 0; k < ANGLE_BINS; k++) begin
                r_shift[k] <= (t_bin'(k) == r_bin) ? sum_sat : r_acc[k];
            end
        end else if (i_cmd.shift) begin
            for (int k = 0; k < ANGLE_BINS - 1; k++) begin
                r_shift[k] <= r_shift[k+1];
            end
            r_shift[ANGLE_BINS-1] <= '0;
        end
    end

    assign o_sts.cell_end = r_cell_end;
    assign o_bin_sum      = r_shift[0];

endmodule

@@ hdl/hogch_ctrl.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram controller
// Sequences one pixel through square, root and accumulate, then emits the
// eight bins of a finished cell one beat at a time.
// ----------------------------------------------------------------------------
`include "hog_cell_histogram_defines.svh"

module hogch_ctrl import hogch_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_bin    o_bin_number,
    output logic    o_final_bin,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ROOT   = 3'd2;
    localparam logic [2:0] ST_ACCUM  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_STEPS - 1);
    localparam t_bin              LAST_BIN  = t_bin'(ANGLE_BINS - 1);

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_bin              r_emit;
    t_bin              n_emit;
    logic              in_beat;
    logic              out_beat;

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = (r_state == ST_EMIT);
    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_emit  = r_emit;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_state = ST_ROOT;
                n_step  = '0;
            end
            ST_ROOT: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_ACCUM;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ACCUM: begin
                n_emit  = '0;
                n_state = i_sts.cell_end ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_beat) begin
                    if (r_emit == LAST_BIN) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit = r_emit + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_emit  <= n_emit;
        end
    end

    assign o_cmd.load      = in_beat;
    assign o_cmd.square    = (r_state == ST_SQUARE);
    assign o_cmd.root_step = (r_state == ST_ROOT);
    assign o_cmd.accum     = (r_state == ST_ACCUM);
    assign o_cmd.snap      = (r_state == ST_ACCUM) && i_sts.cell_end;
    assign o_cmd.shift     = out_beat;

    assign o_bin_number = r_emit;
    assign o_final_bin  = (r_emit == LAST_BIN);

    // The first bin of a cell always leads the emission.
    `HOGCH_ASSERT(a_emit_starts_at_zero, $rose(o_valid) |-> (r_emit == '0))
    // A cell that is being emitted stays on the output until its last bin goes.
    `HOGCH_ASSERT_NEXT(a_emit_holds, out_beat && !o_final_bin, o_valid)
    // The root unit never runs past its last bit.
    `HOGCH_ASSERT(a_root_bound, (r_state == ST_ROOT) |-> (r_step <= LAST_STEP))
    // After the last bin the block is ready for pixels again.
    `HOGCH_ASSERT_NEXT(a_emit_release, out_beat && o_final_bin, !o_stall)

endmodule

@@ hdl/hog_cell_histogram.sv @@
// ----------------------------------------------------------------------------
// HOG cell orientation histogram
// Gradient magnitude per pixel, binned into eight 45 degree sectors per cell.
// ----------------------------------------------------------------------------
// Input channel: one beat per pixel with its four neighbours and cell_end,
// taken when i_valid is high and o_stall is low. Output channel: one beat per
// bin (bin number, saturating sum with 4 fraction bits, final-bin flag), taken
// when o_valid is high and i_stall is low.
// Each pixel occupies the block for the accept, a state to square the
// gradients, the steps of the one-bit-per-cycle square root and a state to
// add into the bin. o_stall is high while the block works on an accepted
// pixel or emits a finished cell.
// On a pixel with cell_end set, the first bin appears once the bin add is done
// and the eight bins follow one per cycle while i_stall is low; a stalled bin
// holds its value. No pixel is taken until the eighth bin is gone.
// Reset clears the bin sums and returns the block to waiting for pixels.
// ----------------------------------------------------------------------------
module hog_cell_histogram import hogch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_left,
    input  logic [PIX_W-1:0] i_pixel_right,
    input  logic [PIX_W-1:0] i_pixel_above,
    input  logic [PIX_W-1:0] i_pixel_below,
    input  logic             i_cell_end,
    output logic             o_valid,
    input  logic             i_stall,
    output t_bin             o_bin_number,
    output t_sum             o_bin_sum,
    output logic             o_final_bin
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    hogch_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_bin_number (o_bin_number),
        .o_final_bin  (o_final_bin),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    hogch_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_left  (i_pixel_left),
        .i_pixel_right (i_pixel_right),
        .i_pixel_above (i_pixel_above),
        .i_pixel_below (i_pixel_below),
        .i_cell_end    (i_cell_end),
        .o_bin_sum     (o_bin_sum)
    );

endmodule
